FILE: design/tcs_pkg.sv
// tcs_pkg: shared types and codes of the timed cue scheduler.
// No dependencies; used by the interfaces and every module of the block but tcs_ram.
`default_nettype none
package tcs_pkg;

  localparam logic [2:0] ACT_BEACON  = 3'd0;
  localparam logic [2:0] ACT_PREPARE = 3'd1;
  localparam logic [2:0] ACT_FIRE    = 3'd2;
  localparam logic [2:0] ACT_CANCEL  = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  localparam logic [1:0] ACK_STORED = 2'd0;
  localparam logic [1:0] ACK_BAD    = 2'd1;
  localparam logic [1:0] ACK_FULL   = 2'd2;

  localparam logic       KIND_ACK   = 1'b0;
  localparam logic       KIND_APPLY = 1'b1;

  localparam logic [31:0] OWN_ID_RESET = 32'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] msg_epoch;
    logic [31:0] cue_id;
    logic [7:0]  pat_code;
    logic [7:0]  bri_level;
    logic [31:0] time_ms;
    logic        ack_req;
    logic        target_is_node;
    logic [31:0] target_id;
    logic        payload_ok;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  ack_code;
    logic [31:0] applied_cue;
    logic [7:0]  applied_pattern;
    logic [7:0]  applied_brightness;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic beacon;
    logic fire_push;
    logic scan_start;
    logic scan_src_fire;
    logic scan_run;
    logic prep_commit;
    logic code_bad;
    logic emit_ack;
    logic fire_begin;
    logic fire_rd;
    logic fire_keep;
    logic fire_skip;
    logic fire_end;
    logic hold_load;
    logic push_hold;
    logic push_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] act;
    logic       ep_ok;
    logic       node_ok;
    logic       pok;
    logic       ack_in;
    logic       ack_q;
    logic       is_tick;
    logic       scan_done;
    logic       scan_hit;
    logic       fire_more;
    logic       fire_keep;
    logic       hold_v;
    logic       out_free;
  } stat_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PSCAN  = 10'b00_0000_0010,
    S_PWR    = 10'b00_0000_0100,
    S_EMIT   = 10'b00_0000_1000,
    S_CSCAN  = 10'b00_0001_0000,
    S_FRD    = 10'b00_0010_0000,
    S_FCHK   = 10'b00_0100_0000,
    S_TSCAN  = 10'b00_1000_0000,
    S_TAPPLY = 10'b01_0000_0000,
    S_TLAST  = 10'b10_0000_0000
  } state_e;

endpackage
`default_nettype wire

FILE: design/tcs_in_if.sv
// tcs_in_if: valid/ready channel carrying one input word.
// Depends on tcs_pkg.
`default_nettype none
interface tcs_in_if;
  logic              valid;
  logic              ready;
  tcs_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/tcs_out_if.sv
// tcs_out_if: valid/ready channel carrying one result word.
// Depends on tcs_pkg.
`default_nettype none
interface tcs_out_if;
  logic               valid;
  logic               ready;
  tcs_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/tcs_ram.sv
// tcs_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none
module tcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output      logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/tcs_ctrl.sv
// tcs_ctrl: sequencer of the cue scheduler.
// Depends on tcs_pkg; drives tcs_dpath through cmd_t, reads stat_t.
`default_nettype none
module tcs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire tcs_pkg::stat_t st_i,
  output      tcs_pkg::cmd_t  cmd_o
);
  tcs_pkg::state_e state_q, state_d;
  logic acc;

  assign in_ready_o = (state_q == tcs_pkg::S_IDLE);
  assign acc        = in_ready_o && in_valid_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      tcs_pkg::S_IDLE: begin
        if (acc) begin
          cmd_o.latch = 1'b1;
          case (st_i.act)
            tcs_pkg::ACT_BEACON: cmd_o.beacon = 1'b1;
            tcs_pkg::ACT_PREPARE: begin
              if (st_i.ep_ok && st_i.node_ok) begin
                if (!st_i.pok) begin
                  cmd_o.code_bad = 1'b1;
                  if (st_i.ack_in) state_d = tcs_pkg::S_EMIT;
                end else begin
                  cmd_o.scan_start = 1'b1;
                  state_d = tcs_pkg::S_PSCAN;
                end
              end
            end
            tcs_pkg::ACT_FIRE: cmd_o.fire_push = st_i.ep_ok && st_i.pok;
            tcs_pkg::ACT_CANCEL: begin
              if (st_i.ep_ok && st_i.pok) begin
                cmd_o.scan_start = 1'b1;
                state_d = tcs_pkg::S_CSCAN;
              end
            end
            tcs_pkg::ACT_TICK: begin
              cmd_o.fire_begin = 1'b1;
              state_d = tcs_pkg::S_FRD;
            end
            default: ;
          endcase
        end
      end
      tcs_pkg::S_PSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) state_d = tcs_pkg::S_PWR;
      end
      tcs_pkg::S_PWR: begin
        cmd_o.prep_commit = 1'b1;
        state_d = st_i.ack_q ? tcs_pkg::S_EMIT : tcs_pkg::S_IDLE;
      end
      tcs_pkg::S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d = tcs_pkg::S_IDLE;
        end
      end
      tcs_pkg::S_CSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) begin
          cmd_o.fire_begin = 1'b1;
          state_d = tcs_pkg::S_FRD;
        end
      end
      tcs_pkg::S_FRD: begin
        if (st_i.fire_more) begin
          cmd_o.fire_rd = 1'b1;
          state_d = tcs_pkg::S_FCHK;
        end else begin
          cmd_o.fire_end = 1'b1;
          state_d = (st_i.is_tick && st_i.hold_v) ? tcs_pkg::S_TLAST : tcs_pkg::S_IDLE;
        end
      end
      tcs_pkg::S_FCHK: begin
        if (st_i.fire_keep) begin
          cmd_o.fire_keep = 1'b1;
          state_d = tcs_pkg::S_FRD;
        end else begin
          cmd_o.fire_skip = 1'b1;
          if (st_i.is_tick) begin
            cmd_o.scan_start    = 1'b1;
            cmd_o.scan_src_fire = 1'b1;
            state_d = tcs_pkg::S_TSCAN;
          end else begin
            state_d = tcs_pkg::S_FRD;
          end
        end
      end
      tcs_pkg::S_TSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) state_d = st_i.scan_hit ? tcs_pkg::S_TAPPLY : tcs_pkg::S_FRD;
      end
      tcs_pkg::S_TAPPLY: begin
        if (!st_i.hold_v) begin
          cmd_o.hold_load = 1'b1;
          state_d = tcs_pkg::S_FRD;
        end else if (st_i.out_free) begin
          cmd_o.push_hold = 1'b1;
          cmd_o.hold_load = 1'b1;
          state_d = tcs_pkg::S_FRD;
        end
      end
      tcs_pkg::S_TLAST: begin
        if (st_i.out_free) begin
          cmd_o.push_hold = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d = tcs_pkg::S_IDLE;
        end
      end
      default: state_d = tcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tcs_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  a_scan_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_run |-> (state_q == tcs_pkg::S_PSCAN || state_q == tcs_pkg::S_CSCAN
                        || state_q == tcs_pkg::S_TSCAN))
    else $error("scan runs outside a scan state");
  a_push_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push_hold || cmd_o.emit_ack) |-> st_i.out_free)
    else $error("result pushed into busy output register");
  a_hold_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.hold_load && st_i.hold_v) |-> cmd_o.push_hold)
    else $error("held result lost");
endmodule
`default_nettype wire

FILE: design/tcs_dpath.sv
// tcs_dpath: cue table, fire list, epoch, held result and output register.
// Depends on tcs_pkg and tcs_ram; steered by tcs_ctrl via cmd_t/stat_t.
`default_nettype none
module tcs_dpath #(
  parameter int CueSlots  = 64,
  parameter int FireSlots = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire tcs_pkg::in_word_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      tcs_pkg::out_word_t out_data_o,
  input  wire tcs_pkg::cmd_t      cmd_i,
  output      tcs_pkg::stat_t     st_o
);
  localparam int Caw  = (CueSlots > 1) ? $clog2(CueSlots) : 1;
  localparam int Ccw  = $clog2(CueSlots + 1);
  localparam int Faw  = (FireSlots > 1) ? $clog2(FireSlots) : 1;
  localparam int Fcw  = $clog2(FireSlots + 1);

  logic [31:0] own_q, epoch_q;
  logic [2:0]  act_q;
  logic [31:0] cue_q, time_q;
  logic [7:0]  pat_q, bri_q;
  logic        ack_q;
  logic [1:0]  code_q;

  logic [CueSlots-1:0] cvalid_q;
  logic [Ccw-1:0]      ca_q;
  logic [Caw-1:0]      idx_q, slot_q, free_q;
  logic                pend_q, found_q, free_v_q;
  logic [31:0]         scan_id_q;
  logic [7:0]          hit_pat_q, hit_bri_q;

  logic [Fcw-1:0]      fcnt_q, rd_q, wr_q;

  logic        hold_v_q;
  logic [31:0] hold_cue_q;
  logic [7:0]  hold_pat_q, hold_bri_q;

  logic               ovalid_q;
  tcs_pkg::out_word_t odata_q;

  // cue RAM: {key, pattern, brightness}
  logic [47:0]    c_rdata, c_wdata;
  logic           c_we, c_re;
  logic [Caw-1:0] c_waddr;
  logic [31:0]    c_rkey;
  logic           match, last_idx, cancel_mode, issue;

  // fire RAM: {key, due}
  logic [63:0]    f_rdata, f_wdata;
  logic           f_we;
  logic [Faw-1:0] f_waddr;
  logic [31:0]    f_key, f_due, t_diff;
  logic           f_due_now, out_free;

  assign c_rkey      = c_rdata[47:16];
  assign cancel_mode = (act_q == tcs_pkg::ACT_CANCEL);
  assign match       = pend_q && cvalid_q[idx_q] && (c_rkey == scan_id_q);
  assign last_idx    = (idx_q == Caw'(CueSlots - 1));
  assign issue       = cmd_i.scan_run && (ca_q < Ccw'(CueSlots));
  assign c_re        = issue;
  assign c_we        = cmd_i.prep_commit && (found_q || free_v_q);
  assign c_waddr     = found_q ? slot_q : free_q;
  assign c_wdata     = {cue_q, pat_q, bri_q};

  tcs_ram #(.Width(48), .Depth(CueSlots)) u_cue_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(ca_q[Caw-1:0]), .rdata_o(c_rdata)
  );

  assign f_key     = f_rdata[63:32];
  assign f_due     = f_rdata[31:0];
  assign t_diff    = time_q - f_due;
  assign f_due_now = !t_diff[31];
  assign f_we      = cmd_i.fire_keep || (cmd_i.fire_push && (fcnt_q < Fcw'(FireSlots)));
  assign f_waddr   = cmd_i.fire_keep ? wr_q[Faw-1:0] : fcnt_q[Faw-1:0];
  assign f_wdata   = cmd_i.fire_keep ? f_rdata : {in_data_i.cue_id, in_data_i.time_ms};

  tcs_ram #(.Width(64), .Depth(FireSlots)) u_fire_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(cmd_i.fire_rd), .raddr_i(rd_q[Faw-1:0]), .rdata_o(f_rdata)
  );

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    st_o           = '0;
    st_o.act       = in_data_i.action;
    st_o.ep_ok     = (epoch_q != '0) && (in_data_i.msg_epoch == epoch_q);
    st_o.node_ok   = !in_data_i.target_is_node || (in_data_i.target_id == own_q);
    st_o.pok       = in_data_i.payload_ok;
    st_o.ack_in    = in_data_i.ack_req;
    st_o.ack_q     = ack_q;
    st_o.is_tick   = (act_q == tcs_pkg::ACT_TICK);
    st_o.scan_done = pend_q && (last_idx || (match && !cancel_mode));
    st_o.scan_hit  = match;
    st_o.fire_more = (rd_q != fcnt_q);
    st_o.fire_keep = (act_q == tcs_pkg::ACT_TICK) ? !f_due_now : (f_key != cue_q);
    st_o.hold_v    = hold_v_q;
    st_o.out_free  = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q    <= tcs_pkg::OWN_ID_RESET;
      epoch_q  <= '0;
      cvalid_q <= '0;
      fcnt_q   <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      ca_q     <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      hold_v_q <= 1'b0;
      ovalid_q <= 1'b0;
      act_q    <= tcs_pkg::ACT_BEACON;
    end else begin
      if (cfg_we_i) own_q <= cfg_wdata_i;
      if (cmd_i.latch) act_q <= in_data_i.action;
      if (cmd_i.beacon && ((epoch_q == '0) || (in_data_i.msg_epoch != epoch_q))) begin
        epoch_q  <= in_data_i.msg_epoch;
        cvalid_q <= '0;
        fcnt_q   <= '0;
      end
      if (f_we && cmd_i.fire_push) fcnt_q <= fcnt_q + Fcw'(1);

      if (cmd_i.scan_start) begin
        ca_q     <= '0;
        pend_q   <= 1'b0;
        found_q  <= 1'b0;
        free_v_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        pend_q <= issue;
        if (issue) ca_q <= ca_q + Ccw'(1);
        if (match) begin
          if (cancel_mode) cvalid_q[idx_q] <= 1'b0;
          else             found_q <= 1'b1;
        end
        if (pend_q && !cvalid_q[idx_q] && !free_v_q) free_v_q <= 1'b1;
      end
      if (cmd_i.prep_commit && !found_q && free_v_q) cvalid_q[free_q] <= 1'b1;

      if (cmd_i.fire_begin) begin
        rd_q <= '0;
        wr_q <= '0;
      end
      if (cmd_i.fire_keep) begin
        rd_q <= rd_q + Fcw'(1);
        wr_q <= wr_q + Fcw'(1);
      end
      if (cmd_i.fire_skip) rd_q <= rd_q + Fcw'(1);
      if (cmd_i.fire_end)  fcnt_q <= wr_q;

      if (cmd_i.hold_load)      hold_v_q <= 1'b1;
      else if (cmd_i.push_last) hold_v_q <= 1'b0;

      if (cmd_i.emit_ack || cmd_i.push_hold) ovalid_q <= 1'b1;
      else if (out_ready_i)                  ovalid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cue_q  <= in_data_i.cue_id;
      pat_q  <= in_data_i.pat_code;
      bri_q  <= in_data_i.bri_level;
      time_q <= in_data_i.time_ms;
      ack_q  <= in_data_i.ack_req;
      code_q <= cmd_i.code_bad ? tcs_pkg::ACK_BAD : tcs_pkg::ACK_STORED;
    end
    if (cmd_i.prep_commit && !found_q && !free_v_q) code_q <= tcs_pkg::ACK_FULL;
    if (cmd_i.scan_start) scan_id_q <= cmd_i.scan_src_fire ? f_key : in_data_i.cue_id;
    if (cmd_i.scan_run) begin
      if (issue) idx_q <= ca_q[Caw-1:0];
      if (match && !found_q) begin
        slot_q    <= idx_q;
        hit_pat_q <= c_rdata[15:8];
        hit_bri_q <= c_rdata[7:0];
      end
      if (pend_q && !cvalid_q[idx_q] && !free_v_q) free_q <= idx_q;
    end
    if (cmd_i.hold_load) begin
      hold_cue_q <= scan_id_q;
      hold_pat_q <= hit_pat_q;
      hold_bri_q <= (hit_bri_q == 8'd0) ? 8'd1 : hit_bri_q;
    end
    // ack word: cue fields zero, always the last word of its message
    if (cmd_i.emit_ack) begin
      odata_q <= {tcs_pkg::KIND_ACK, code_q, 32'd0, 8'd0, 8'd0, 1'b1};
    end else if (cmd_i.push_hold) begin
      odata_q.kind               <= tcs_pkg::KIND_APPLY;
      odata_q.ack_code           <= tcs_pkg::ACK_STORED;
      odata_q.applied_cue        <= hold_cue_q;
      odata_q.applied_pattern    <= hold_pat_q;
      odata_q.applied_brightness <= hold_bri_q;
      odata_q.last               <= cmd_i.push_last;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= Fcw'(FireSlots))
    else $error("fire count beyond list size");
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("compaction write ran ahead of read");
  a_last_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_last |=> !hold_v_q)
    else $error("held result left after last push");
endmodule
`default_nettype wire

FILE: design/timed_cue_scheduler.sv
// timed_cue_scheduler: top level of the cue table / timed fire list block.
// Depends on tcs_pkg, tcs_in_if, tcs_out_if, tcs_ram, tcs_ctrl, tcs_dpath.
//
// Usage:
//  - in_i: one message word (beacon, prepare, fire, cancel, tick) per
//    valid/ready handshake. out_o: result words, ack or applied cue, with
//    last set on the final word of a message.
//  - cfg_we_i/cfg_wdata_i write own_node_id; write only while idle.
//  - One message at a time. Beacon and fire end on acceptance. Prepare and
//    cancel scan the cue RAM, one entry per cycle. Cancel then walks the
//    fire RAM, as does tick, with a read and a check per entry; each due
//    fire on a tick adds a cue RAM lookup plus an apply step when the cue
//    is found.
//  - Tick results are held one deep so the last flag can be set on the
//    final one; a result goes out through a one-word output register.
//  - A stalled receiver only holds the sequencer when a new result needs
//    the output register; otherwise the next message is accepted.
//  - Reset: empty cue table and fire list, epoch 0, node id 1. No clearing
//    pass; the block is ready as soon as reset is released.
`default_nettype none
module timed_cue_scheduler #(
  parameter int CUE_SLOTS  = 64,
  parameter int FIRE_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  tcs_in_if.sink           in_i,
  tcs_out_if.source        out_o
);
  tcs_pkg::cmd_t  cmd;
  tcs_pkg::stat_t st;

  // sequencer: one message at a time
  tcs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .st_i(st),
    .cmd_o(cmd)
  );

  // storage, scan counters and output register
  tcs_dpath #(.CueSlots(CUE_SLOTS), .FireSlots(FIRE_SLOTS)) u_dpath (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_data_i(in_i.data),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o(out_o.data),
    .cmd_i(cmd),
    .st_o(st)
  );
endmodule
`default_nettype wire
